// ===== src/lrc_pkg.sv =====
`timescale 1ns / 1ps
package lrc_pkg;

	localparam int KEY_W  = 37;
	localparam int DATE_W = 27;
	localparam int TAG_W  = 64;
	localparam int SIZE_W = 5;
	localparam int RANK_OUT_W = 4;

	localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [DATE_W-1:0] date;
		logic [TAG_W-1:0]  tag;
	} rec_t;

	typedef struct packed {
		logic                  hit;
		logic [RANK_OUT_W-1:0] hit_rank;
		logic [DATE_W-1:0]     stored_birth_date;
		logic [TAG_W-1:0]      stored_tag;
		logic                  evicted;
		logic [KEY_W-1:0]      evicted_key;
	} result_t;

endpackage

// ===== src/lrc_rec_if.sv =====
`timescale 1ns / 1ps
interface lrc_rec_if;
	logic                         valid;
	logic                         ready;
	logic [lrc_pkg::KEY_W-1:0]    key;
	logic [lrc_pkg::DATE_W-1:0]   birth_date;
	logic [lrc_pkg::TAG_W-1:0]    record_tag;

	modport source (output valid, output key, output birth_date, output record_tag,
		input ready);
	modport sink (input valid, input key, input birth_date, input record_tag,
		output ready);
endinterface

// ===== src/lrc_res_if.sv =====
`timescale 1ns / 1ps
interface lrc_res_if;
	logic                            valid;
	logic                            ready;
	logic                            hit;
	logic [lrc_pkg::RANK_OUT_W-1:0]  hit_rank;
	logic [lrc_pkg::DATE_W-1:0]      stored_birth_date;
	logic [lrc_pkg::TAG_W-1:0]       stored_tag;
	logic                            evicted;
	logic [lrc_pkg::KEY_W-1:0]       evicted_key;

	modport source (output valid, output hit, output hit_rank, output stored_birth_date,
		output stored_tag, output evicted, output evicted_key, input ready);
	modport sink (input valid, input hit, input hit_rank, input stored_birth_date,
		input stored_tag, input evicted, input evicted_key, output ready);
endinterface

// ===== src/lrc_cfg_if.sv =====
`timescale 1ns / 1ps
interface lrc_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [lrc_pkg::SIZE_W-1:0]    data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== src/lru_record_cache.sv =====
`timescale 1ns / 1ps
// Channel  | Modport | Payload                                        | Role
// ---------+---------+------------------------------------------------+------------------------
// rec_in   | sink    | key, birth_date, record_tag                    | lookup/insert request
// res_out  | source  | hit, hit_rank, stored_birth_date, stored_tag,  | one result per request
//          |         | evicted, evicted_key                           |
// cfg      | sink    | data (cache_size)                              | size register write
//
// A miss with n > 0 occupied entries walks the sequencer through a scan of all n entries
// (registered RAM reads, one entry per cycle), one plan step, an aging pass on the rank
// RAM, one write-back and one hand-off. A hit at slot k ends the scan there; an empty
// cache skips the scan. rec_in.ready is high only while idle, so idle follows each hand-off.
// The hand-off stalls while the output register holds a result not yet taken.
// Reset clears occupancy, sets cache_size to 16; only occupied RAM entries are read.
module lru_record_cache #(
	parameter int CAPACITY = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	lrc_rec_if.sink    rec_in,
	lrc_res_if.source  res_out,
	lrc_cfg_if.sink    cfg
);
	localparam int AW = $clog2(CAPACITY);

	logic [lrc_pkg::SIZE_W-1:0] size_q;

	logic             start;
	lrc_pkg::rec_t    start_rec;
	logic             busy;
	logic             seq_res_valid;
	logic             seq_res_ready;
	lrc_pkg::result_t seq_res;

	logic             out_v_q;
	lrc_pkg::result_t out_q;

	logic             rec_we;
	logic [AW-1:0]    rec_waddr;
	lrc_pkg::rec_t    rec_wdata;
	logic [AW-1:0]    rec_raddr;
	lrc_pkg::rec_t    rec_rdata;
	logic             rk_we;
	logic [AW-1:0]    rk_waddr;
	logic [AW-1:0]    rk_wdata;
	logic [AW-1:0]    rk_raddr;
	logic [AW-1:0]    rk_rdata;

	// size register: always writable; the user must write it only while idle, not enforced here
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= lrc_pkg::SIZE_RESET;
		end else if (cfg.valid) begin
			size_q <= cfg.data;
		end
	end

	// request side
	assign rec_in.ready  = !busy;
	assign start         = rec_in.valid && !busy;
	assign start_rec.key  = rec_in.key;
	assign start_rec.date = rec_in.birth_date;
	assign start_rec.tag  = rec_in.record_tag;

	lrc_seq #(
		.CAPACITY(CAPACITY)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.start_rec  (start_rec),
		.cache_size (size_q),
		.busy       (busy),
		.res_valid  (seq_res_valid),
		.res_ready  (seq_res_ready),
		.res        (seq_res),
		.rec_we     (rec_we),
		.rec_waddr  (rec_waddr),
		.rec_wdata  (rec_wdata),
		.rec_raddr  (rec_raddr),
		.rec_rdata  (rec_rdata),
		.rk_we      (rk_we),
		.rk_waddr   (rk_waddr),
		.rk_wdata   (rk_wdata),
		.rk_raddr   (rk_raddr),
		.rk_rdata   (rk_rdata)
	);

	lrc_rec_store #(
		.CAPACITY(CAPACITY)
	) u_rec_store (
		.clk   (clk),
		.we    (rec_we),
		.waddr (rec_waddr),
		.wdata (rec_wdata),
		.raddr (rec_raddr),
		.rdata (rec_rdata)
	);

	lrc_rank_store #(
		.CAPACITY(CAPACITY)
	) u_rank_store (
		.clk   (clk),
		.we    (rk_we),
		.waddr (rk_waddr),
		.wdata (rk_wdata),
		.raddr (rk_raddr),
		.rdata (rk_rdata)
	);

	// output register: takes a new result when empty or being drained
	assign seq_res_ready = !out_v_q || res_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (seq_res_ready) begin
			out_v_q <= seq_res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (seq_res_valid && seq_res_ready) begin
			out_q <= seq_res;
		end
	end

	assign res_out.valid             = out_v_q;
	assign res_out.hit               = out_q.hit;
	assign res_out.hit_rank          = out_q.hit_rank;
	assign res_out.stored_birth_date = out_q.stored_birth_date;
	assign res_out.stored_tag        = out_q.stored_tag;
	assign res_out.evicted           = out_q.evicted;
	assign res_out.evicted_key       = out_q.evicted_key;

	// a taken request closes the request side in the next cycle
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> !rec_in.ready)
		else $error("request side open right after a request was taken");

	// a finished result never coexists with an open request side
	a_done_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		seq_res_valid |-> !rec_in.ready)
		else $error("request side open while a result is pending");

	// a handed-over result shows up on the output channel
	a_result_lands: assert property (@(posedge clk) disable iff (!arst_n)
		seq_res_valid && seq_res_ready |=> res_out.valid)
		else $error("result lost between sequencer and output register");

	// a hit never reports an eviction
	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		res_out.valid |-> !(res_out.hit && res_out.evicted))
		else $error("hit and eviction reported together");
endmodule

// ===== src/lrc_rec_store.sv =====
`timescale 1ns / 1ps
// Record RAM: one write port, one registered read port.
module lrc_rec_store #(
	parameter int CAPACITY = 16
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [$clog2(CAPACITY)-1:0] waddr,
	input  lrc_pkg::rec_t               wdata,
	input  logic [$clog2(CAPACITY)-1:0] raddr,
	output lrc_pkg::rec_t               rdata
);
	lrc_pkg::rec_t mem [CAPACITY];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== src/lrc_rank_store.sv =====
`timescale 1ns / 1ps
// Recency rank RAM: one write port, one registered read port.
module lrc_rank_store #(
	parameter int CAPACITY = 16
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [$clog2(CAPACITY)-1:0] waddr,
	input  logic [$clog2(CAPACITY)-1:0] wdata,
	input  logic [$clog2(CAPACITY)-1:0] raddr,
	output logic [$clog2(CAPACITY)-1:0] rdata
);
	logic [$clog2(CAPACITY)-1:0] mem [CAPACITY];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== src/lrc_seq.sv =====
`timescale 1ns / 1ps
// Sequencer: scan pass (key compare + oldest search), aging pass, write-back.
module lrc_seq #(
	parameter int CAPACITY = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  lrc_pkg::rec_t                 start_rec,
	input  logic [lrc_pkg::SIZE_W-1:0]    cache_size,
	output logic                          busy,
	output logic                          res_valid,
	input  logic                          res_ready,
	output lrc_pkg::result_t              res,
	output logic                          rec_we,
	output logic [$clog2(CAPACITY)-1:0]   rec_waddr,
	output lrc_pkg::rec_t                 rec_wdata,
	output logic [$clog2(CAPACITY)-1:0]   rec_raddr,
	input  lrc_pkg::rec_t                 rec_rdata,
	output logic                          rk_we,
	output logic [$clog2(CAPACITY)-1:0]   rk_waddr,
	output logic [$clog2(CAPACITY)-1:0]   rk_wdata,
	output logic [$clog2(CAPACITY)-1:0]   rk_raddr,
	input  logic [$clog2(CAPACITY)-1:0]   rk_rdata
);
	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int SW = (CW > lrc_pkg::SIZE_W) ? CW : lrc_pkg::SIZE_W;
	localparam int EW = (AW > lrc_pkg::RANK_OUT_W) ? AW : lrc_pkg::RANK_OUT_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_PLAN,
		S_AGE,
		S_WRITE,
		S_DONE
	} state_t;

	state_t          state_q;
	logic [CW-1:0]   occ_q;
	logic [CW-1:0]   iss_q;
	logic            v_s1;
	logic            wv_s1;
	logic            hit_q;
	logic            evict_q;
	logic            grow_q;
	logic            age_all_q;

	lrc_pkg::rec_t   in_q;
	logic [AW-1:0]   idx_s1;
	logic [AW-1:0]   widx_s1;
	logic [AW-1:0]   hrank_q;
	logic [AW-1:0]   hslot_q;
	logic [AW-1:0]   max_q;
	logic [AW-1:0]   mslot_q;
	logic [AW-1:0]   limit_q;
	logic [AW-1:0]   target_q;
	logic [lrc_pkg::DATE_W-1:0] sdate_q;
	logic [lrc_pkg::TAG_W-1:0]  stag_q;
	logic [lrc_pkg::KEY_W-1:0]  ekey_q;

	logic [SW-1:0]   cfg_ext;
	logic [SW-1:0]   size_eff;
	logic            full;
	logic [AW-1:0]   last_idx;
	logic            issue;
	logic            match;
	logic            scan_end;
	logic [EW-1:0]   hr_ext;

	// effective size: 0 acts as 1, above capacity clamps
	assign cfg_ext  = SW'(cache_size);
	assign size_eff = (cfg_ext == '0) ? SW'(1) :
		(cfg_ext > SW'(CAPACITY)) ? SW'(CAPACITY) : cfg_ext;
	assign full     = SW'(occ_q) >= size_eff;
	assign last_idx = AW'(occ_q - CW'(1));
	assign issue    = iss_q < occ_q;
	assign match    = v_s1 && (rec_rdata.key == in_q.key);
	assign scan_end = v_s1 && (match || idx_s1 == last_idx);

	assign rec_raddr = iss_q[AW-1:0];
	assign rk_raddr  = iss_q[AW-1:0];

	always_comb begin
		rk_we    = 1'b0;
		rk_waddr = widx_s1;
		rk_wdata = rk_rdata + AW'(1);
		if (state_q == S_AGE) begin
			rk_we = wv_s1 && (age_all_q || rk_rdata < limit_q);
		end else if (state_q == S_WRITE) begin
			rk_we    = 1'b1;
			rk_waddr = target_q;
			rk_wdata = '0;
		end
	end

	assign rec_we    = (state_q == S_WRITE) && !hit_q;
	assign rec_waddr = target_q;
	assign rec_wdata = in_q;

	assign busy      = state_q != S_IDLE;
	assign res_valid = state_q == S_DONE;
	assign hr_ext    = EW'(hrank_q);

	always_comb begin
		res.hit               = hit_q;
		res.hit_rank          = hit_q ? hr_ext[lrc_pkg::RANK_OUT_W-1:0] : '0;
		res.stored_birth_date = hit_q ? sdate_q : '0;
		res.stored_tag        = hit_q ? stag_q : '0;
		res.evicted           = evict_q;
		res.evicted_key       = evict_q ? ekey_q : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			occ_q     <= '0;
			iss_q     <= '0;
			v_s1      <= 1'b0;
			wv_s1     <= 1'b0;
			hit_q     <= 1'b0;
			evict_q   <= 1'b0;
			grow_q    <= 1'b0;
			age_all_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						iss_q   <= '0;
						v_s1    <= 1'b0;
						hit_q   <= 1'b0;
						evict_q <= 1'b0;
						state_q <= (occ_q == '0) ? S_PLAN : S_SCAN;
					end
				end
				S_SCAN: begin
					v_s1 <= issue;
					if (issue) begin
						iss_q <= iss_q + CW'(1);
					end
					if (match) begin
						hit_q <= 1'b1;
					end
					if (scan_end) begin
						state_q <= S_PLAN;
					end
				end
				S_PLAN: begin
					iss_q     <= '0;
					v_s1      <= 1'b0;
					wv_s1     <= 1'b0;
					age_all_q <= !hit_q && !full;
					grow_q    <= !hit_q && !full;
					evict_q   <= !hit_q && full;
					state_q   <= S_AGE;
				end
				S_AGE: begin
					wv_s1 <= issue;
					if (issue) begin
						iss_q <= iss_q + CW'(1);
					end
					if (!issue && !wv_s1) begin
						state_q <= S_WRITE;
					end
				end
				S_WRITE: begin
					if (grow_q) begin
						occ_q <= occ_q + CW'(1);
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			in_q    <= start_rec;
			max_q   <= '0;
			mslot_q <= '0;
		end
		if (state_q == S_SCAN) begin
			idx_s1 <= iss_q[AW-1:0];
			if (v_s1 && rk_rdata >= max_q) begin
				max_q   <= rk_rdata;
				mslot_q <= idx_s1;
				ekey_q  <= rec_rdata.key;
			end
			if (match) begin
				hrank_q <= rk_rdata;
				hslot_q <= idx_s1;
				sdate_q <= rec_rdata.date;
				stag_q  <= rec_rdata.tag;
			end
		end
		if (state_q == S_PLAN) begin
			if (hit_q) begin
				limit_q  <= hrank_q;
				target_q <= hslot_q;
			end else if (full) begin
				limit_q  <= max_q;
				target_q <= mslot_q;
			end else begin
				limit_q  <= '0;
				target_q <= occ_q[AW-1:0];
			end
		end
		if (state_q == S_AGE) begin
			widx_s1 <= iss_q[AW-1:0];
		end
	end
endmodule

// ===== test/lrc_cache_checker.sv =====
`timescale 1ns / 1ps
module lrc_cache_checker #(
	parameter int CAPACITY = 16
) (
	input  logic clk,
	input  logic arst_n,
	lrc_rec_if   rec,
	lrc_res_if   res,
	lrc_cfg_if   cfg,
	output int   mismatches,
	output int   outstanding,
	output int   hits_seen,
	output int   evictions_seen
);
	// shadow copy of the cache contents
	logic [lrc_pkg::KEY_W-1:0]  slot_key  [CAPACITY];
	logic [lrc_pkg::DATE_W-1:0] slot_date [CAPACITY];
	logic [lrc_pkg::TAG_W-1:0]  slot_tag  [CAPACITY];
	int unsigned                slot_age  [CAPACITY];
	int unsigned                filled;
	logic [lrc_pkg::SIZE_W-1:0] size_reg;

	lrc_pkg::result_t expected_q[$];
	int      fail_n;
	int      hit_n;
	int      evict_n;

	// 0 behaves as 1, anything over the built capacity as the capacity
	function automatic int unsigned size_limit();
		int unsigned s;
		s = size_reg;
		if (s < 1)
			s = 1;
		if (s > CAPACITY)
			s = CAPACITY;
		return s;
	endfunction

	function automatic void age_newer(int unsigned limit);
		for (int i = 0; i < filled; i++)
			if (slot_age[i] < limit)
				slot_age[i]++;
	endfunction

	// look the record up, update recency and contents, return the result
	function automatic lrc_pkg::result_t lookup_record(lrc_pkg::rec_t r);
		lrc_pkg::result_t outcome;
		int               slot;
		int unsigned      oldest;
		outcome = '0;
		slot = -1;
		for (int i = 0; i < filled; i++)
			if (slot < 0 && slot_key[i] == r.key)
				slot = i;
		if (slot >= 0) begin
			outcome.hit = 1'b1;
			outcome.hit_rank = lrc_pkg::RANK_OUT_W'(slot_age[slot]);
			outcome.stored_birth_date = slot_date[slot];
			outcome.stored_tag = slot_tag[slot];
			age_newer(slot_age[slot]);
			slot_age[slot] = 0;
			return outcome;
		end
		if (filled < size_limit()) begin
			slot = filled;
			age_newer(32'hFFFF_FFFF);
			filled++;
		end else begin
			// full, or shrunk below fill: replace the oldest entry in place
			oldest = 0;
			slot = 0;
			for (int i = 0; i < filled; i++)
				if (slot_age[i] >= oldest) begin
					oldest = slot_age[i];
					slot = i;
				end
			outcome.evicted = 1'b1;
			outcome.evicted_key = slot_key[slot];
			age_newer(oldest);
		end
		slot_key[slot] = r.key;
		slot_date[slot] = r.date;
		slot_tag[slot] = r.tag;
		slot_age[slot] = 0;
		return outcome;
	endfunction

	function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fail_n++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		lrc_pkg::result_t want;
		lrc_pkg::result_t got;
		lrc_pkg::rec_t    item;
		if (!arst_n) begin
			filled = 0;
			size_reg = lrc_pkg::SIZE_RESET;
			foreach (slot_age[i])
				slot_age[i] = 0;
			expected_q.delete();
			fail_n = 0;
			hit_n = 0;
			evict_n = 0;
			mismatches <= 0;
			outstanding <= 0;
			hits_seen <= 0;
			evictions_seen <= 0;
		end else begin
			// results first: a result can never belong to a same-edge request
			if (res.valid && res.ready) begin
				got.hit = res.hit;
				got.hit_rank = res.hit_rank;
				got.stored_birth_date = res.stored_birth_date;
				got.stored_tag = res.stored_tag;
				got.evicted = res.evicted;
				got.evicted_key = res.evicted_key;
				if (expected_q.size() == 0) begin
					$error("result with no request pending");
					fail_n++;
				end else begin
					want = expected_q.pop_front();
					check_field("hit", want.hit, got.hit);
					check_field("hit_rank", want.hit_rank, got.hit_rank);
					check_field("stored_birth_date", want.stored_birth_date,
						got.stored_birth_date);
					check_field("stored_tag", want.stored_tag, got.stored_tag);
					check_field("evicted", want.evicted, got.evicted);
					check_field("evicted_key", want.evicted_key, got.evicted_key);
					hit_n += want.hit;
					evict_n += want.evicted;
				end
			end
			if (cfg.valid && cfg.ready)
				size_reg = cfg.data;
			if (rec.valid && rec.ready) begin
				item = {rec.key, rec.birth_date, rec.record_tag};
				expected_q.push_back(lookup_record(item));
			end
			mismatches <= fail_n;
			outstanding <= expected_q.size();
			hits_seen <= hit_n;
			evictions_seen <= evict_n;
		end
	end

endmodule

// ===== test/tb_lru_record_cache.sv =====
`timescale 1ns / 1ps
module tb_lru_record_cache;
	localparam int CAPACITY     = 16;
	localparam int PHASES       = 10;
	localparam int PHASE_ITEMS  = 103;
	localparam int POOL_N       = 32;
	// one request at most scans and ages every entry
	localparam int DRAIN_CYCLES = 2 * CAPACITY + 8;
	// long result-side hold-off used to back the block up
	localparam int HOLD_CYCLES  = 400;
	// cycles with no handshake on any channel before the run is declared hung;
	// covers the hold-off, a full request and long random stall runs
	localparam int QUIET_LIMIT  = 3000;

	localparam logic [lrc_pkg::KEY_W-1:0]  KEY_MAX  = 37'd99999999999;
	localparam logic [lrc_pkg::DATE_W-1:0] DATE_MAX = 27'd99991231;

	logic clk;
	logic arst_n;

	lrc_rec_if rec_in();
	lrc_res_if res_out();
	lrc_cfg_if cfg();

	int mismatches;
	int outstanding;
	int hits_seen;
	int evictions_seen;

	// idling knobs, set per phase
	int   send_idle_pct  = 0;
	int   recv_stall_pct = 0;
	logic hold_req       = 1'b0;

	int                        sent = 0;
	int                        size_plan [PHASES];
	logic [lrc_pkg::KEY_W-1:0] key_pool  [POOL_N];
	logic [lrc_pkg::KEY_W-1:0] last_key;

	lru_record_cache #(.CAPACITY(CAPACITY)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rec_in (rec_in),
		.res_out(res_out),
		.cfg    (cfg)
	);

	lrc_cache_checker #(.CAPACITY(CAPACITY)) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.rec           (rec_in),
		.res           (res_out),
		.cfg           (cfg),
		.mismatches    (mismatches),
		.outstanding   (outstanding),
		.hits_seen     (hits_seen),
		.evictions_seen(evictions_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Result side. Random stalls at the phase's rate; a rising hold_req starts
	// one long hold-off, counted here, while the sender keeps offering requests.
	initial begin
		int   hold_left;
		logic hold_seen;
		hold_left = 0;
		hold_seen = 1'b0;
		res_out.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_seen)
				hold_left = HOLD_CYCLES;
			hold_seen = hold_req;
			if (hold_left > 0) begin
				hold_left--;
				res_out.ready <= 1'b0;
			end else
				res_out.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Hang detector: counts cycles in which no channel moves anything.
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((rec_in.valid && rec_in.ready) || (res_out.valid && res_out.ready)
					|| (cfg.valid && cfg.ready))
				quiet = 0;
			else
				quiet++;
		end
		$error("no handshake for %0d cycles", QUIET_LIMIT);
		$display("*** FAILED ***");
		$finish;
	end

	// random ID inside the legal eleven-digit range
	function automatic logic [lrc_pkg::KEY_W-1:0] fresh_key();
		return lrc_pkg::KEY_W'({$urandom, $urandom} % 64'd100000000000);
	endfunction

	// Offer one request, with random idle cycles in front of it. Valid stays
	// high from one request to the next unless a gap is inserted.
	task automatic send_record(input logic [lrc_pkg::KEY_W-1:0] k,
			input logic [lrc_pkg::DATE_W-1:0] d, input logic [lrc_pkg::TAG_W-1:0] t);
		while ($urandom_range(99) < send_idle_pct) begin
			rec_in.valid <= 1'b0;
			@(posedge clk);
		end
		rec_in.valid      <= 1'b1;
		rec_in.key        <= k;
		rec_in.birth_date <= d;
		rec_in.record_tag <= t;
		do @(posedge clk); while (!rec_in.ready);
		sent++;
		last_key = k;
	endtask

	// Keys mostly come from a pool a little larger than the active size, so
	// hits, hits at every rank and evictions all show up; some are repeats of
	// the last key (rank 0 hit) and some are brand new.
	task automatic send_random(input int window);
		logic [lrc_pkg::KEY_W-1:0]  k;
		logic [lrc_pkg::DATE_W-1:0] d;
		int                         pick;
		pick = $urandom_range(99);
		if (pick < 10)
			k = last_key;
		else if (pick < 22)
			k = fresh_key();
		else
			k = key_pool[$urandom_range(window - 1)];
		case ($urandom_range(15))
			0:       d = '0;
			1:       d = DATE_MAX;
			default: d = lrc_pkg::DATE_W'($urandom_range(99991231));
		endcase
		send_record(k, d, {$urandom, $urandom});
	endtask

	// Size writes only with the block idle: every request answered.
	task automatic write_size(input logic [lrc_pkg::SIZE_W-1:0] v);
		rec_in.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		cfg.valid <= 1'b1;
		cfg.data  <= v;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
	endtask

	initial begin
		int eff;
		int window;
		arst_n = 1'b0;
		rec_in.valid = 1'b0;
		rec_in.key = '0;
		rec_in.birth_date = '0;
		rec_in.record_tag = '0;
		cfg.valid = 1'b0;
		cfg.data = '0;
		last_key = '0;

		// includes shrinking below fill (16 -> 4), 0 and 31 out of range,
		// 17 just over capacity, and both real extremes 1 and 16
		size_plan = '{4, 1, 16, 0, 31, 2, 17, 9, 16, 3};
		key_pool[0] = '0;
		key_pool[1] = KEY_MAX;
		for (int i = 2; i < POOL_N; i++)
			key_pool[i] = fresh_key();

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, at the reset size of 16, no idling.
		send_record('0, '0, '0);                       // empty cache miss
		send_record(KEY_MAX, DATE_MAX, '1);             // largest legal key and date, all-ones tag
		send_record('0, 27'd1, 64'h1);                  // hit, rank 1, zero data back
		send_record(KEY_MAX, '0, '0);                   // hit, rank 1, max data back
		send_record(KEY_MAX, '0, '0);                   // hit on the newest
		for (int i = 0; i < 14; i++)                    // fill to 16
			send_record(37'd1000 + lrc_pkg::KEY_W'(i), lrc_pkg::DATE_W'(i * 7000000),
				{$urandom, $urandom});
		send_record('0, DATE_MAX, 64'hA5A5_5A5A_0F0F_F0F0); // hit on the oldest, rank 15
		send_record(37'h5555, 27'h2AA_AAAA, 64'h5555_AAAA_5555_AAAA); // evicts max key
		send_record(37'd1006, '0, '0);                  // hit in the middle
		send_record(KEY_MAX, DATE_MAX, '1);             // evicted key comes back
		send_record(KEY_MAX, '0, '0);                   // and is found again

		// Random phases, cycling through the idling patterns.
		for (int p = 0; p < PHASES; p++) begin
			write_size(lrc_pkg::SIZE_W'(size_plan[p]));
			case (p % 4)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct <= 0;
				end
				1: begin
					send_idle_pct = 58;
					recv_stall_pct <= 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct <= 58;
				end
				default: begin
					send_idle_pct = 8;
					recv_stall_pct <= 8;
				end
			endcase
			// two phases open with the long result-side hold-off
			hold_req <= (p == 2 || p == 7);
			eff = size_plan[p];
			if (eff < 1)
				eff = 1;
			if (eff > CAPACITY)
				eff = CAPACITY;
			window = eff + 3;
			repeat (PHASE_ITEMS)
				send_random(window);
		end

		rec_in.valid <= 1'b0;
		hold_req <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		// nothing more may come out once the last answer is in
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d requests, sizes 0..31 incl. shrink below fill and back-pressure;",
			sent);
		$display("%0d hits, %0d evictions, %0d field mismatches", hits_seen, evictions_seen,
			mismatches);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/lrc_pkg.sv
src/lrc_rec_if.sv
src/lrc_res_if.sv
src/lrc_cfg_if.sv
src/lrc_rec_store.sv
src/lrc_rank_store.sv
src/lrc_seq.sv
src/lru_record_cache.sv
test/lrc_cache_checker.sv
test/tb_lru_record_cache.sv
